[sv/avpm_pkg.sv]
package avpm_pkg;

  localparam int VOICES     = 8;
  localparam int VW         = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int BANK_BYTES = 65536;
  localparam int BANK_AW    = $clog2(BANK_BYTES);
  localparam int IDX_MAX    = 88;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_PLAY = 2'd1,
    OP_STOP = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VREAD,
    ST_BREAD,
    ST_DECODE,
    ST_ACCUM,
    ST_MIX,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    CFG_MID   = 3'd0,
    CFG_UKNEE = 3'd1,
    CFG_LKNEE = 3'd2,
    CFG_URAIL = 3'd3,
    CFG_LRAIL = 3'd4
  } cfg_idx_t;

  // packed per-voice record kept in the voice memory
  // len holds up to 131072 nibbles, so it needs 18 bits
  typedef struct packed {
    logic signed [15:0] pred;
    logic [6:0]         idx;
    logic [16:0]        pos;
    logic [17:0]        len;
    logic [15:0]        start;
    logic [7:0]         gain;
    logic               looping;
  } voice_t;

  function automatic logic [14:0] step_lookup(input logic [6:0] i);
    logic [14:0] s;
    case (i)
      7'd0: s = 15'd7;      7'd1: s = 15'd8;      7'd2: s = 15'd9;
      7'd3: s = 15'd10;     7'd4: s = 15'd11;     7'd5: s = 15'd12;
      7'd6: s = 15'd13;     7'd7: s = 15'd14;     7'd8: s = 15'd16;
      7'd9: s = 15'd17;     7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

endpackage

[sv/avpm_sample_mem.sv]
module avpm_sample_mem
  import avpm_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [BANK_AW-1:0] wr_addr,
  input  logic [7:0]         wr_data,
  input  logic [BANK_AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [BANK_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/avpm_voice_mem.sv]
module avpm_voice_mem
  import avpm_pkg::*;
(
  input  logic          clk,
  input  logic          wr_en,
  input  logic [VW-1:0] wr_addr,
  input  voice_t        wr_data,
  input  logic [VW-1:0] rd_addr,
  output voice_t        rd_data
);

  voice_t mem [VOICES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/avpm_decoder.sv]
module avpm_decoder
  import avpm_pkg::*;
(
  input  voice_t       vin,
  input  logic [3:0]   nib,
  output voice_t       vout,
  output logic         ended
);

  logic [14:0]        step;
  logic [17:0]        delta;
  logic signed [17:0] p;
  logic signed [8:0]  ni;
  logic [6:0]         idx;
  logic [17:0]        pos1;

  always_comb begin
    idx   = (vin.idx > 7'(IDX_MAX)) ? 7'(IDX_MAX) : vin.idx;
    step  = step_lookup(idx);
    delta = 18'(step >> 3);
    if (nib[2]) delta = delta + 18'(step);
    if (nib[1]) delta = delta + 18'(step >> 1);
    if (nib[0]) delta = delta + 18'(step >> 2);
    p = nib[3] ? (18'(vin.pred) - $signed(delta)) : (18'(vin.pred) + $signed(delta));
    if (p > 18'sd32767) p = 18'sd32767;
    else if (p < -18'sd32768) p = -18'sd32768;
    ni = nib[2] ? ($signed({2'b0, idx}) + $signed({6'b0, nib[1:0], 1'b0}) + 9'sd2)
                : ($signed({2'b0, idx}) - 9'sd1);
    if (ni < 0) ni = '0;
    else if (ni > 9'(IDX_MAX)) ni = 9'(IDX_MAX);
    pos1  = 18'(vin.pos) + 18'd1;
    ended = pos1 >= 18'(vin.len);
    vout      = vin;
    vout.pred = p[15:0];
    vout.idx  = ni[6:0];
    vout.pos  = pos1[16:0];
    if (ended && vin.looping) begin
      vout.pred = '0;
      vout.idx  = '0;
      vout.pos  = '0;
    end
  end

endmodule

[sv/adpcm_voice_pool_mixer.sv]
// adpcm voice pool mixer
//
// command channel: an item is taken when start is high and busy is low.
// operation 0 writes a byte to the sample memory, 1 starts a voice,
// 2 stops a voice, 3 ticks every playing voice and mixes them.
// load, play and stop give no result.
// a tick gives one result, strobed by done for one cycle; the receiver
// cannot stall it, so the block never waits on the output side.
// tick: every voice slot is checked in turn, and a playing one then goes
// through the sample byte read, the decode and write-back, the multiply and
// the accumulate; after the last slot the mix stage shapes the sum, and
// done is registered from the mix stage; the next item can be taken in the
// cycle in which done is high.
// config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken; they are meant only while the block is idle.
// reset clears the playing flags and restores the register defaults;
// sample memory and voice records stay undefined until written.
module adpcm_voice_pool_mixer
  import avpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [2:0]  voice,
  input  logic [15:0] address,
  input  logic [7:0]  data_byte,
  input  logic [17:0] nibble_count,
  input  logic [7:0]  volume,
  input  logic        loop_enable,
  output logic        done,
  output logic [10:0] pwm_sample,
  output logic [7:0]  active_mask,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  // configuration registers
  logic [10:0] mid_level, soft_upper_knee, soft_lower_knee, upper_rail, lower_rail;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_level       <= 11'd719;
      soft_upper_knee <= 11'd1290;
      soft_lower_knee <= 11'd148;
      upper_rail      <= 11'd1430;
      lower_rail      <= 11'd8;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MID:   mid_level       <= cfg_data;
        CFG_UKNEE: soft_upper_knee <= cfg_data;
        CFG_LKNEE: soft_lower_knee <= cfg_data;
        CFG_URAIL: upper_rail      <= cfg_data;
        CFG_LRAIL: lower_rail      <= cfg_data;
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  state_t state, state_next;
  logic [VW-1:0]     vsel, vsel_next;
  logic [VOICES-1:0] playing, playing_next;
  logic signed [17:0] mix, mix_next;
  logic signed [15:0] pred_q;
  logic [7:0]         gain_q;
  logic signed [9:0]  pshift;
  logic signed [18:0] prod_q;
  logic               last_voice;

  voice_t vrd, vwr, vdec;
  logic   v_we, ended, s_we;
  logic [VW-1:0] v_wa;
  logic [BANK_AW-1:0] s_ra;
  logic [7:0] s_rd;
  logic [3:0] nib;
  logic [16:0] abyte;

  logic accept;
  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  avpm_sample_mem u_smem (
    .clk(clk), .wr_en(s_we), .wr_addr(address[BANK_AW-1:0]),
    .wr_data(data_byte), .rd_addr(s_ra), .rd_data(s_rd)
  );

  avpm_voice_mem u_vmem (
    .clk(clk), .wr_en(v_we), .wr_addr(v_wa), .wr_data(vwr),
    .rd_addr(vsel), .rd_data(vrd)
  );

  avpm_decoder u_dec (.vin(vrd), .nib(nib), .vout(vdec), .ended(ended));

  // byte address of the current nibble, wrapped to the bank
  assign abyte = 17'(vrd.start) + 17'(vrd.pos[16:1]);
  assign s_ra  = abyte[BANK_AW-1:0];
  assign nib   = vrd.pos[0] ? s_rd[7:4] : s_rd[3:0];
  assign s_we  = accept && (op_t'(operation) == OP_LOAD);
  assign last_voice = (32'(vsel) == VOICES - 1);

  // play command builds a fresh voice record
  logic [17:0] ncnt;
  voice_t vplay;
  always_comb begin
    ncnt = nibble_count;
    if (ncnt == '0) ncnt = 18'd1;
    if (ncnt > 18'd131072) ncnt = 18'd131072;
    vplay.pred    = '0;
    vplay.idx     = '0;
    vplay.pos     = '0;
    vplay.len     = ncnt;
    vplay.start   = address;
    vplay.gain    = volume;
    vplay.looping = loop_enable;
  end

  // contribution: ((pred >>> 6) * gain) >>> 8, multiply registered first
  assign pshift = 10'(pred_q >>> 6);

  always_ff @(posedge clk) begin
    prod_q <= 19'(pshift) * 19'($signed({1'b0, gain_q}));
    if (state == ST_DECODE) begin
      pred_q <= vdec.pred;
      gain_q <= vrd.gain;
    end
  end

  // play/stop commands and voice walk: check slot, read byte, decode, multiply, accumulate, mix
  always_comb begin
    state_next   = state;
    vsel_next    = vsel;
    playing_next = playing;
    mix_next     = mix;
    v_we         = 1'b0;
    v_wa         = vsel;
    vwr          = vdec;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(operation))
            OP_PLAY: begin
              if (32'(voice) < VOICES) begin
                v_we = 1'b1;
                v_wa = VW'(voice);
                vwr  = vplay;
                playing_next[VW'(voice)] = 1'b1;
              end
            end
            OP_STOP: begin
              if (32'(voice) < VOICES) playing_next[VW'(voice)] = 1'b0;
            end
            OP_TICK: begin
              vsel_next  = '0;
              mix_next   = '0;
              state_next = ST_VREAD;
            end
            default: ;
          endcase
        end
      end
      ST_VREAD: begin
        if (playing[vsel]) state_next = ST_BREAD;
        else if (last_voice) state_next = ST_MIX;
        else vsel_next = vsel + VW'(1);
      end
      ST_BREAD: state_next = ST_DECODE;
      ST_DECODE: begin
        v_we = 1'b1;
        if (ended && !vrd.looping) playing_next[vsel] = 1'b0;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        // prod_q registered this cycle from pred_q of decode
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        mix_next = mix + 18'(prod_q >>> 8);
        if (last_voice) state_next = ST_MIX;
        else begin
          vsel_next  = vsel + VW'(1);
          state_next = ST_VREAD;
        end
      end
      ST_MIX: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      playing <= '0;
    end else begin
      state   <= state_next;
      playing <= playing_next;
    end
    vsel <= vsel_next;
    mix  <= mix_next;
  end

  // output shaping: centre, soft knees, rails, all in signed arithmetic
  logic signed [19:0] mid_s, uk_s, lk_s, ur_s, lr_s;
  assign mid_s = $signed({9'b0, mid_level});
  assign uk_s  = $signed({9'b0, soft_upper_knee});
  assign lk_s  = $signed({9'b0, soft_lower_knee});
  assign ur_s  = $signed({9'b0, upper_rail});
  assign lr_s  = $signed({9'b0, lower_rail});

  logic signed [19:0] s0, s1, s2;
  always_comb begin
    s0 = 20'(mix) + mid_s;
    s1 = s0;
    if (s0 > uk_s)
      s1 = uk_s + ((s0 - uk_s) >>> 2);
    else if (s0 < lk_s)
      s1 = lk_s - ((lk_s - s0) >>> 2);
    s2 = s1;
    if (s1 > ur_s) s2 = ur_s;
    else if (s1 < lr_s) s2 = lr_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_MIX);
    end
    if (state == ST_MIX) begin
      pwm_sample  <= s2[10:0];
      active_mask <= 8'(playing);
    end
  end

endmodule
